// ----- design/two_pkg.sv -----
// Package for the tracking wheel odometry block.
// Holds op codes, register indexes, fixed-point constants and the CORDIC arctangent table.
package two_pkg;
   localparam logic [1:0] OP_UPDATE = 2'd0;
   localparam logic [1:0] OP_RESET  = 2'd1;
   localparam logic [1:0] OP_INIT   = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   localparam logic [1:0] REG_DIST_PER_TICK = 2'd0;
   localparam logic [1:0] REG_H_OFFSET      = 2'd1;
   localparam logic [1:0] REG_V_OFFSET      = 2'd2;

   localparam logic signed [17:0] DEG_Q8_FULL    = 18'sd92160;
   localparam logic signed [17:0] DEG_Q8_HALF    = 18'sd46080;
   localparam logic signed [17:0] DEG_Q8_QUARTER = 18'sd23040;
   localparam logic signed [25:0] PI_OVER_180_Q30 = 26'sd18740330;
   localparam logic signed [32:0] CORDIC_GAIN_Q30 = 33'sd652032874;
   localparam logic signed [47:0] POS_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] POS_MIN = 48'sh8000_0000_0000;

   // A whole number of full turns that lifts any 32-bit heading above zero.
   localparam logic [32:0] HEAD_BIAS = 33'd2147512320;
   // Reciprocal of 45 in Q28, exact for quotients of 22-bit values.
   localparam logic [22:0] RECIP_45 = 23'd5965233;

   function automatic logic [29:0] atan_q30(input logic [4:0] i);
      logic [29:0] v;
      case (i)
         5'd0: v = 30'd843314857;
         5'd1: v = 30'd497837829;
         5'd2: v = 30'd263043837;
         5'd3: v = 30'd133525159;
         5'd4: v = 30'd67021687;
         5'd5: v = 30'd33543516;
         5'd6: v = 30'd16775851;
         5'd7: v = 30'd8388437;
         5'd8: v = 30'd4194283;
         5'd9: v = 30'd2097149;
         5'd10: v = 30'd1048575;
         5'd31: v = 30'd0;
         default: v = 30'd1 << (5'd30 - i);
      endcase
      return v;
   endfunction
endpackage

// ----- design/two_cordic.sv -----
// Iterative CORDIC rotator: one micro-rotation per cycle.
// Depends on two_pkg for the gain and arctangent table.
module two_cordic #(
   parameter int CORDIC_STEPS = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] angle,
   output logic               done,
   output logic signed [33:0] sin_q30,
   output logic signed [33:0] cos_q30
);
   import two_pkg::*;
   localparam int CW = $clog2(CORDIC_STEPS + 1);

   logic signed [33:0] x_ff, y_ff;
   logic signed [31:0] z_ff;
   logic [CW-1:0] i_ff;
   logic busy_ff, done_ff;
   logic [4:0] idx;

   assign idx = 5'(i_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            x_ff <= 34'(CORDIC_GAIN_Q30);
            y_ff <= '0;
            z_ff <= angle;
            i_ff <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (z_ff >= 0) begin
               x_ff <= x_ff - (y_ff >>> idx);
               y_ff <= y_ff + (x_ff >>> idx);
               z_ff <= z_ff - $signed({2'b00, atan_q30(idx)});
            end else begin
               x_ff <= x_ff + (y_ff >>> idx);
               y_ff <= y_ff - (x_ff >>> idx);
               z_ff <= z_ff + $signed({2'b00, atan_q30(idx)});
            end
            i_ff <= i_ff + 1'b1;
            if (i_ff == CW'(CORDIC_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign sin_q30 = y_ff;
   assign cos_q30 = x_ff;
endmodule

// ----- design/tracking_wheel_odometry.sv -----
// Top level of the tracking wheel odometry block.
// Uses two_pkg and two_cordic; one shared multiplier under a sequencer.
//
// Every product on the shared 25x34 multiplier is formed low half first, then high
// half; the CORDIC iterations run alongside the distance and turn products, and the
// wait for them sets the length of an update beat. Reset, init and unused-op beats
// go from idle straight to the output state. The result register holds the last
// beat until taken, and the block is not ready while one item works or while a
// result waits for the previous one.
module tracking_wheel_odometry #(
   parameter int CORDIC_STEPS = 24
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // op[1:0], vertical_count[33:2], horizontal_count[65:34], gyro_heading[97:66]
   input  logic [103:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // pos_x[47:0], pos_y[95:48], heading_out[127:96]
   output logic [127:0] rsp_tdata,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [23:0]  csr_wdata
);
   import two_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_RED, S_FOLD, S_DV, S_DH, S_RAD, S_RH, S_RV, S_SUM, S_WAIT,
      S_M0, S_M1, S_M2, S_M3, S_ACC, S_OUT
   } state_type;

   state_type state_ff;
   logic [23:0] dpt_ff;
   logic signed [15:0] hoff_ff, voff_ff;
   logic signed [31:0] lastv_ff, lasth_ff, head_ff, gyro_ff, vc_ff, hc_ff;
   logic signed [47:0] gx_ff, gy_ff;
   logic signed [33:0] s_ff, c_ff;
   logic flip_ff;
   logic signed [31:0] z_ff;
   logic signed [47:0] distv_ff, disth_ff, rad_ff, roth_ff, rotv_ff, lx_ff, ly_ff;
   logic signed [49:0] accx_ff, accy_ff;
   logic signed [17:0] r_ff;
   logic [16:0] q_ff;
   logic ph_ff;
   logic signed [58:0] plo_ff;
   logic cstart_ff;
   logic cdone;
   logic signed [33:0] csin, ccos;
   logic [127:0] out_ff;
   logic ovalid_ff;

   logic [1:0] in_op;
   logic signed [31:0] in_vc, in_hc, in_gy;
   assign in_op = req_tdata[1:0];
   assign in_vc = req_tdata[33:2];
   assign in_hc = req_tdata[65:34];
   assign in_gy = req_tdata[97:66];

   // Shared multiplier: 48x34 signed products formed in two 25x34 halves.
   logic signed [47:0] ma;
   logic signed [33:0] mb;
   logic signed [24:0] mha;
   logic signed [58:0] mhalf;
   logic signed [81:0] mp;
   logic mul_st;
   always_comb begin
      ma = '0;
      mb = '0;
      case (state_ff)
         S_DV:  begin ma = 48'(vc_ff) - 48'(lastv_ff); mb = 34'($signed({1'b0, dpt_ff})); end
         S_DH:  begin ma = 48'(hc_ff) - 48'(lasth_ff); mb = 34'($signed({1'b0, dpt_ff})); end
         S_RAD: begin ma = 48'(gyro_ff) - 48'(head_ff); mb = 34'(PI_OVER_180_Q30); end
         S_RH:  begin ma = rad_ff; mb = -34'(hoff_ff); end
         S_RV:  begin ma = rad_ff; mb = 34'(voff_ff); end
         S_M0:  begin ma = lx_ff; mb = c_ff; end
         S_M1:  begin ma = ly_ff; mb = s_ff; end
         S_M2:  begin ma = lx_ff; mb = s_ff; end
         S_M3:  begin ma = ly_ff; mb = c_ff; end
         default: begin ma = '0; mb = '0; end
      endcase
   end
   assign mul_st = state_ff inside {S_DV, S_DH, S_RAD, S_RH, S_RV, S_M0, S_M1, S_M2, S_M3};
   assign mha = ph_ff ? $signed({ma[47], ma[47:24]}) : $signed({1'b0, ma[23:0]});
   assign mhalf = 59'(mha) * 59'(mb);
   assign mp = (82'(mhalf) <<< 24) + 82'(plo_ff);

   // Rounded shift right (half up) of the product.
   function automatic logic signed [47:0] rsr(input logic signed [81:0] v, input int s);
      logic signed [81:0] t;
      t = (v + (82'sd1 <<< (s - 1))) >>> s;
      return t[47:0];
   endfunction

   // Q30 product, rounded half away from zero.
   function automatic logic signed [47:0] rq30(input logic signed [81:0] v);
      logic signed [81:0] a;
      logic signed [81:0] t;
      a = v[81] ? -v : v;
      t = (a + (82'sd1 <<< 29)) >>> 30;
      return v[81] ? -t[47:0] : t[47:0];
   endfunction

   function automatic logic signed [47:0] sat(input logic signed [49:0] v);
      if (v > 50'(POS_MAX)) return POS_MAX;
      if (v < 50'(POS_MIN)) return POS_MIN;
      return v[47:0];
   endfunction

   // Heading reduced modulo a full turn through a reciprocal multiply.
   logic [32:0] hu;
   logic [44:0] qprod;
   logic [16:0] rem;
   assign hu = 33'(head_ff) + HEAD_BIAS;
   assign qprod = 45'(hu[32:11]) * 45'(RECIP_45);
   assign rem = 17'(hu - 33'(q_ff) * 33'(DEG_Q8_FULL));

   // Heading reduction to within a quarter turn.
   logic signed [17:0] rmod;
   logic signed [18:0] rf;
   logic fl;
   always_comb begin
      rmod = $signed({1'b0, rem});
      if (rmod >= DEG_Q8_HALF) rmod = rmod - DEG_Q8_FULL;
      rf = 19'(rmod);
      fl = 1'b0;
      if (rmod > DEG_Q8_QUARTER) begin
         rf = 19'(rmod) - 19'(DEG_Q8_HALF);
         fl = 1'b1;
      end else if (rmod < -DEG_Q8_QUARTER) begin
         rf = 19'(rmod) + 19'(DEG_Q8_HALF);
         fl = 1'b1;
      end
   end

   logic signed [44:0] zprod;
   assign zprod = 45'(r_ff) * 45'(PI_OVER_180_Q30) + 45'sd128;

   two_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock(clock), .reset(reset), .start(cstart_ff), .angle(z_ff),
      .done(cdone), .sin_q30(csin), .cos_q30(ccos)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         dpt_ff <= 24'd402624;
         hoff_ff <= '0;
         voff_ff <= '0;
         lastv_ff <= '0;
         lasth_ff <= '0;
         head_ff <= '0;
         gx_ff <= '0;
         gy_ff <= '0;
         ovalid_ff <= 1'b0;
         cstart_ff <= 1'b0;
         ph_ff <= 1'b0;
      end else begin
         cstart_ff <= 1'b0;
         if (csr_we) begin
            case (csr_index)
               REG_DIST_PER_TICK: dpt_ff <= csr_wdata;
               REG_H_OFFSET: hoff_ff <= csr_wdata[15:0];
               REG_V_OFFSET: voff_ff <= csr_wdata[15:0];
               default: ;
            endcase
         end
         if (ovalid_ff && rsp_tready && state_ff != S_OUT) ovalid_ff <= 1'b0;
         if (mul_st && !ph_ff) begin
            ph_ff <= 1'b1;
            plo_ff <= mhalf;
         end else begin
            ph_ff <= 1'b0;
            case (state_ff)
               S_IDLE: begin
                  if (req_tvalid) begin
                     vc_ff <= in_vc;
                     hc_ff <= in_hc;
                     gyro_ff <= in_gy;
                     case (in_op)
                        OP_UPDATE: state_ff <= S_RED;
                        OP_RESET, OP_INIT: begin
                           gx_ff <= '0;
                           gy_ff <= '0;
                           head_ff <= (in_op == OP_RESET) ? in_gy : '0;
                           lastv_ff <= in_vc;
                           lasth_ff <= in_hc;
                           state_ff <= S_OUT;
                        end
                        default: state_ff <= S_OUT;
                     endcase
                  end
               end
               S_RED: begin
                  q_ff <= qprod[44:28];
                  state_ff <= S_FOLD;
               end
               S_FOLD: begin
                  r_ff <= rf[17:0];
                  flip_ff <= fl;
                  state_ff <= S_DV;
               end
               S_DV: begin
                  z_ff <= 32'(zprod >>> 8);
                  cstart_ff <= 1'b1;
                  distv_ff <= rsr(mp, 12);
                  state_ff <= S_DH;
               end
               S_DH:  begin disth_ff <= rsr(mp, 12); state_ff <= S_RAD; end
               S_RAD: begin rad_ff <= rsr(mp, 14); state_ff <= S_RH; end
               S_RH:  begin roth_ff <= rsr(mp, 20); state_ff <= S_RV; end
               S_RV:  begin rotv_ff <= rsr(mp, 20); state_ff <= S_SUM; end
               S_SUM: begin
                  lx_ff <= distv_ff + rotv_ff;
                  ly_ff <= disth_ff + roth_ff;
                  state_ff <= S_WAIT;
               end
               S_WAIT: begin
                  if (cdone) begin
                     s_ff <= flip_ff ? -csin : csin;
                     c_ff <= flip_ff ? -ccos : ccos;
                     state_ff <= S_M0;
                  end
               end
               S_M0: begin accx_ff <= 50'(gx_ff) + 50'(rq30(mp)); state_ff <= S_M1; end
               S_M1: begin accx_ff <= accx_ff - 50'(rq30(mp)); state_ff <= S_M2; end
               S_M2: begin accy_ff <= 50'(gy_ff) + 50'(rq30(mp)); state_ff <= S_M3; end
               S_M3: begin accy_ff <= accy_ff + 50'(rq30(mp)); state_ff <= S_ACC; end
               S_ACC: begin
                  gx_ff <= sat(accx_ff);
                  gy_ff <= sat(accy_ff);
                  head_ff <= gyro_ff;
                  lastv_ff <= vc_ff;
                  lasth_ff <= hc_ff;
                  state_ff <= S_OUT;
               end
               S_OUT: begin
                  if (!ovalid_ff || rsp_tready) begin
                     out_ff <= {head_ff, gy_ff, gx_ff};
                     ovalid_ff <= 1'b1;
                     state_ff <= S_IDLE;
                  end
               end
               default: state_ff <= S_IDLE;
            endcase
         end
      end
   end

   assign req_tready = (state_ff == S_IDLE) && !reset;
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata = out_ff;

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready) else $error("accepted twice");
   a_out_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == S_OUT)) else $error("stray result");
   a_cordic_done: assert property (@(posedge clock) disable iff (reset)
      cdone |-> (state_ff == S_WAIT || state_ff == S_RH || state_ff == S_RV
                 || state_ff == S_SUM)) else $error("cordic done out of place");
endmodule
